/* hw/rtl/odr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and compare helper for the DR/BDR election block.
package odr_pkg;

  // Neighbor record, one per input transaction.
  typedef struct packed {
    logic        present;
    logic [31:0] neighbor_id;
    logic [31:0] neighbor_address;
    logic [7:0]  neighbor_priority;
    logic        two_way;
    logic        claims_dr;
    logic        claims_bdr;
    logic [31:0] claimed_dr_address;
    logic [31:0] claimed_bdr_address;
    logic        last;
  } odr_in_t;

  // Election result, one per output transaction.
  typedef struct packed {
    logic [31:0] dr_id;
    logic [31:0] dr_address;
    logic [31:0] bdr_id;
    logic [31:0] bdr_address;
    logic [1:0]  new_role;
    logic        role_changed;
    logic        start_low_priority;
    logic        recheck_adjacency;
  } odr_out_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [31:0] own_router_id;
    logic [31:0] own_address;
    logic [7:0]  own_priority;
    logic        is_nbma;
  } odr_cfg_t;

  // One election candidate; priority 0 marks an empty slot.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] addr;
    logic [7:0]  pri;
  } odr_cand_t;

  // Running bests frozen at the end of a neighbor list.
  typedef struct packed {
    odr_cand_t dr;
    odr_cand_t bdr;
    odr_cand_t other;
  } odr_snap_t;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_ROUTER_ID = 2'd0,
    CFG_OWN_ADDRESS   = 2'd1,
    CFG_OWN_PRIORITY  = 2'd2,
    CFG_IS_NBMA       = 2'd3
  } odr_cfg_idx_e;

  // Role codes as reported on new_role.
  localparam logic [1:0] ROLE_OTHER   = 2'd0;
  localparam logic [1:0] ROLE_BACKUP  = 2'd1;
  localparam logic [1:0] ROLE_DR      = 2'd2;
  localparam logic [1:0] ROLE_WAITING = 2'd3;

  localparam logic [7:0] OwnPriorityRst = 8'd1;

  // Higher priority wins, then higher router id; a tie keeps the incumbent.
  function automatic logic beats(odr_cand_t a, odr_cand_t b);
    return {a.pri, a.id} > {b.pri, b.id};
  endfunction

endpackage

/* hw/rtl/odr_accum.sv */
`timescale 1ns / 1ps
// Running-best accumulator over one neighbor list, with end-of-list snapshot.
module odr_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  odr_pkg::odr_in_t   item_i,
  output logic               item_take_o,
  output logic               snap_valid_o,
  output odr_pkg::odr_snap_t snap_o,
  input  logic               snap_pop_i
);

  odr_pkg::odr_cand_t best_dr_q, best_dr_d;
  odr_pkg::odr_cand_t best_bdr_q, best_bdr_d;
  odr_pkg::odr_cand_t best_other_q, best_other_d;
  odr_pkg::odr_snap_t snap_q, snap_d;
  logic               snap_valid_q, snap_valid_d;
  logic               counts;
  logic               close_list;
  odr_pkg::odr_cand_t nbr_dr, nbr_bdr, nbr_other;

  // Hold a last item until the snapshot slot is free.
  assign item_take_o = item_valid_i && (!item_i.last || !snap_valid_q || snap_pop_i);
  assign close_list  = item_take_o && item_i.last;
  assign counts      = item_i.present && item_i.two_way && (item_i.neighbor_priority != 8'd0);

  always_comb begin
    nbr_dr    = '{id: item_i.neighbor_id, addr: item_i.claimed_dr_address,
                  pri: item_i.neighbor_priority};
    nbr_bdr   = '{id: item_i.neighbor_id, addr: item_i.claimed_bdr_address,
                  pri: item_i.neighbor_priority};
    nbr_other = '{id: item_i.neighbor_id, addr: item_i.neighbor_address,
                  pri: item_i.neighbor_priority};
    best_dr_d    = best_dr_q;
    best_bdr_d   = best_bdr_q;
    best_other_d = best_other_q;
    if (counts) begin
      if (item_i.claims_dr) begin
        if (odr_pkg::beats(nbr_dr, best_dr_q)) begin
          best_dr_d = nbr_dr;
        end
      end else begin
        if (item_i.claims_bdr && odr_pkg::beats(nbr_bdr, best_bdr_q)) begin
          best_bdr_d = nbr_bdr;
        end
        if (odr_pkg::beats(nbr_other, best_other_q)) begin
          best_other_d = nbr_other;
        end
      end
    end
    snap_d = '{dr: best_dr_d, bdr: best_bdr_d, other: best_other_d};
  end

  assign snap_valid_d = (snap_valid_q && !snap_pop_i) || close_list;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dr_q    <= '0;
      best_bdr_q   <= '0;
      best_other_q <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      if (close_list) begin
        best_dr_q    <= '0;
        best_bdr_q   <= '0;
        best_other_q <= '0;
      end else if (item_take_o) begin
        best_dr_q    <= best_dr_d;
        best_bdr_q   <= best_bdr_d;
        best_other_q <= best_other_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_list) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

/* hw/rtl/odr_elect.sv */
`timescale 1ns / 1ps
// Election with own entry, interface role tracking and result register.
module odr_elect (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  odr_pkg::odr_cfg_t  cfg_i,
  input  logic               snap_valid_i,
  input  odr_pkg::odr_snap_t snap_i,
  output logic               snap_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output odr_pkg::odr_out_t  out_data_o
);

  typedef struct packed {
    odr_pkg::odr_cand_t dr;
    odr_pkg::odr_cand_t bdr;
  } pair_t;

  typedef enum logic [3:0] {
    ST_OTHER   = 4'b0001,
    ST_BACKUP  = 4'b0010,
    ST_DR      = 4'b0100,
    ST_WAITING = 4'b1000
  } role_state_e;

  role_state_e       role_q, role_d;
  logic [31:0]       cur_dr_q, cur_bdr_q;
  logic              out_valid_q, out_valid_d;
  odr_pkg::odr_out_t out_q, out_d;
  pair_t             pass1, pass2, final_pair;
  logic              rerun;
  logic              was_b, was_d, was_o, was_w;
  logic              is_b, is_d, is_o;
  logic              changed;

  function automatic pair_t elect(odr_pkg::odr_cfg_t cfg, odr_pkg::odr_snap_t s,
                                  logic [31:0] cd, logic [31:0] cb);
    logic               elig;
    logic               self_b;
    odr_pkg::odr_cand_t self_c;
    odr_pkg::odr_cand_t b;
    odr_pkg::odr_cand_t d;
    pair_t              r;
    elig   = cfg.own_priority != 8'd0;
    self_b = elig && (cd != cfg.own_router_id);
    self_c = '{id: cfg.own_router_id, addr: cfg.own_address, pri: cfg.own_priority};
    b      = s.bdr;
    if (self_b && (cb == cfg.own_router_id) && odr_pkg::beats(self_c, b)) begin
      b = self_c;
    end
    if (b.pri == 8'd0) begin
      b = s.other;
      if (self_b && odr_pkg::beats(self_c, b)) begin
        b = self_c;
      end
    end
    if (b.pri == 8'd0) begin
      b.id   = '0;
      b.addr = '0;
    end
    d = s.dr;
    if (elig && (cd == cfg.own_router_id) && odr_pkg::beats(self_c, d)) begin
      d = self_c;
    end
    if (d.pri == 8'd0) begin
      d = b;
    end
    r.dr  = d;
    r.bdr = b;
    return r;
  endfunction

  assign snap_pop_o  = snap_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = (out_valid_q && out_stall_i) || snap_pop_o;

  always_comb begin
    pass1 = elect(cfg_i, snap_i, cur_dr_q, cur_bdr_q);
    // Entering or leaving a DR/BDR role: run once more with the new ids.
    rerun = ((pass1.dr.id != '0) &&
             ((cur_dr_q == cfg_i.own_router_id) != (pass1.dr.id == cfg_i.own_router_id))) ||
            ((pass1.bdr.id != '0) &&
             ((cur_bdr_q == cfg_i.own_router_id) != (pass1.bdr.id == cfg_i.own_router_id)));
    pass2      = elect(cfg_i, snap_i, pass1.dr.id, pass1.bdr.id);
    final_pair = rerun ? pass2 : pass1;
  end

  always_comb begin
    was_b = cur_bdr_q == cfg_i.own_router_id;
    was_d = cur_dr_q == cfg_i.own_router_id;
    was_o = role_q == ST_OTHER;
    was_w = !was_b && !was_d && !was_o;
    is_b  = final_pair.bdr.id == cfg_i.own_router_id;
    is_d  = final_pair.dr.id == cfg_i.own_router_id;
    is_o  = !is_b && !is_d;

    // Apply transitions in order; the last one taken sets the role.
    role_d  = role_q;
    changed = 1'b0;
    if (was_b) begin
      if (is_d) begin role_d = ST_DR;    changed = 1'b1; end
      if (is_o) begin role_d = ST_OTHER; changed = 1'b1; end
    end
    if (was_d) begin
      if (is_b) begin role_d = ST_BACKUP; changed = 1'b1; end
      if (is_o) begin role_d = ST_OTHER;  changed = 1'b1; end
    end
    if (was_o) begin
      if (is_d) begin role_d = ST_DR;     changed = 1'b1; end
      if (is_b) begin role_d = ST_BACKUP; changed = 1'b1; end
    end
    if (was_w) begin
      if (is_d) begin role_d = ST_DR;     changed = 1'b1; end
      if (is_b) begin role_d = ST_BACKUP; changed = 1'b1; end
      if (is_o) begin role_d = ST_OTHER;  changed = 1'b1; end
    end

    out_d.dr_id       = final_pair.dr.id;
    out_d.dr_address  = final_pair.dr.addr;
    out_d.bdr_id      = final_pair.bdr.id;
    out_d.bdr_address = final_pair.bdr.addr;
    case (role_d)
      ST_OTHER:  out_d.new_role = odr_pkg::ROLE_OTHER;
      ST_BACKUP: out_d.new_role = odr_pkg::ROLE_BACKUP;
      ST_DR:     out_d.new_role = odr_pkg::ROLE_DR;
      default: begin
        // Still waiting: report what this router became.
        out_d.new_role = is_d ? odr_pkg::ROLE_DR :
                         (is_b ? odr_pkg::ROLE_BACKUP : odr_pkg::ROLE_OTHER);
      end
    endcase
    out_d.role_changed       = changed;
    out_d.start_low_priority = cfg_i.is_nbma && ((!was_b && is_b) || (!was_d && is_d));
    out_d.recheck_adjacency  = (final_pair.dr.id != cur_dr_q) ||
                               (final_pair.bdr.id != cur_bdr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q      <= ST_WAITING;
      cur_dr_q    <= '0;
      cur_bdr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (snap_pop_o) begin
        role_q    <= role_d;
        cur_dr_q  <= final_pair.dr.id;
        cur_bdr_q <= final_pair.bdr.id;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/ospf_dr_bdr_election.sv */
`timescale 1ns / 1ps
// Top level of the OSPF DR/BDR election block.
// A last-marked neighbor transaction passes the input register (loaded at acceptance),
// then the list snapshot register, then the result register; stalls can hold it between them.
// Throughput: one neighbor transaction per cycle, except that a last item waits while the
// snapshot slot is full; each record meets the three running bests in combinational compares.
// Reset: rst_ni (async, active low) clears all bests, current DR/BDR ids to zero,
// the interface role to waiting, and loads the configuration reset values.
module ospf_dr_bdr_election (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [odr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [odr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  odr_pkg::odr_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output odr_pkg::odr_out_t             out_data_o
);

  // Configuration registers; the user writes them only while idle, not enforced by the block.
  odr_pkg::odr_cfg_t  cfg_q;

  // Input register stage.
  logic               in_valid_q, in_valid_d;
  odr_pkg::odr_in_t   in_q;
  logic               in_accept;
  logic               item_take;

  // Snapshot handoff between accumulator and election.
  logic               snap_valid;
  odr_pkg::odr_snap_t snap;
  logic               snap_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_router_id <= '0;
      cfg_q.own_address   <= '0;
      cfg_q.own_priority  <= odr_pkg::OwnPriorityRst;
      cfg_q.is_nbma       <= 1'b0;
    end else if (cfg_we_i) begin
      case (odr_pkg::odr_cfg_idx_e'(cfg_index_i))
        odr_pkg::CFG_OWN_ROUTER_ID: cfg_q.own_router_id <= cfg_wdata_i;
        odr_pkg::CFG_OWN_ADDRESS:   cfg_q.own_address   <= cfg_wdata_i;
        odr_pkg::CFG_OWN_PRIORITY:  cfg_q.own_priority  <= cfg_wdata_i[7:0];
        odr_pkg::CFG_IS_NBMA:       cfg_q.is_nbma       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stall only while a held record cannot move on; ordinary records always
  // drain, so only a last item facing a full result path holds the input.
  assign in_stall_o = in_valid_q && !item_take;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = (in_valid_q && !item_take) || in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the transaction payload on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Fold each neighbor into the running bests; freeze them on the last item.
  odr_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_q),
    .item_take_o  (item_take),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_pop_i   (snap_pop)
  );

  // Merge own entry, re-run once if our role flips, update role, register result.
  odr_elect u_elect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_pop_o   (snap_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

/* hw/rtl/odr_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the election block and its bind.
module odr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input odr_pkg::odr_out_t out_data_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Input stalls only under output backpressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // The waiting role is never reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.new_role != odr_pkg::ROLE_WAITING)
    else $error("waiting role reported");

  // Newly DR or BDR cannot leave the role at other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.start_low_priority |->
      out_data_o.new_role != odr_pkg::ROLE_OTHER)
    else $error("start flag with role other");

endmodule

bind ospf_dr_bdr_election odr_checker u_odr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
